FILE: rtl/ppd_pkg.sv
`timescale 1ns / 1ps

package ppd_pkg;

    // stream widths
    localparam int IN_W     = 384;
    localparam int OUT_W    = 56;
    localparam int DIST_W   = 51;

    // arithmetic widths
    localparam int CRD_W    = 33;   // edge and offset components
    localparam int PRD_W    = 66;   // 33 x 33 partial products
    localparam int NRM_W    = 67;   // signed normal components
    localparam int NSQ_W    = 132;  // one squared normal component
    localparam int TRM_W    = 100;  // one signed dot product term
    localparam int N_W      = 134;  // squared normal length
    localparam int D_W      = 99;   // magnitude of the dot product
    localparam int D2_W     = 198;  // squared dot product
    localparam int SRCH_W   = 200;  // trial value q^2 * N
    localparam int QN_W     = 168;  // running q * N
    localparam int Q_W      = 33;   // root bits; q < 2^33 for any input

    // running state of the bit-by-bit root search
    typedef struct packed {
        logic [SRCH_W-1:0] s;   // q^2 * N
        logic [QN_W-1:0]   p;   // q * N
        logic [Q_W-1:0]    q;   // distance bits found so far
    } srch_t;

endpackage

FILE: rtl/point_plane_distance_unit.sv
`timescale 1ns / 1ps
// throughput: one request per cycle while the output is not stalled; a stalled output fills pipeline bubbles first
// nine arithmetic stages, then one stage per root bit (33), then the output register
// reset: rst_n asynchronous active low clears all valid bits; payload is not reset

module point_plane_distance_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // base_x, base_y, base_z, second_x, second_y, second_z,
    // third_x, third_y, third_z, query_x, query_y, query_z
    input  logic [ppd_pkg::IN_W-1:0]     s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // distance, zero pad
    output logic [ppd_pkg::OUT_W-1:0]    m_tdata,
    // degenerate
    output logic                         m_tuser
);
    import ppd_pkg::*;

    // input fields
    logic signed [31:0]        fld [12];

    // stage 1: edges and offset
    logic signed [CRD_W-1:0]   e1_next [3], e2_next [3], off_next [3];
    logic signed [CRD_W-1:0]   e1_reg [3], e2_reg [3], off1_reg [3];
    logic                      v1_reg, en1;

    // stage 2: cross product terms
    logic signed [PRD_W-1:0]   cp_next [6];
    logic signed [PRD_W-1:0]   cp_reg [6];
    logic signed [CRD_W-1:0]   off2_reg [3];
    logic                      v2_reg, en2;

    // stage 3: magnitudes and signs
    logic signed [NRM_W-1:0]   nrm [3];
    logic [PRD_W-1:0]          nabs_next [3];
    logic [CRD_W-1:0]          oabs_next [3];
    logic [PRD_W-1:0]          nabs_reg [3];
    logic [CRD_W-1:0]          oabs_reg [3];
    logic                      tneg3_reg [3];
    logic                      dg3_reg, v3_reg, en3;

    // stage 4: partial products
    logic [PRD_W-1:0]          ll_reg [3], lh_reg [3], hh_reg [3], lo_reg [3], ho_reg [3];
    logic                      tneg4_reg [3];
    logic                      dg4_reg, v4_reg, en4;

    // stage 5: squared components and dot terms
    logic [NSQ_W-1:0]          nsq_next [3];
    logic [D_W-1:0]            tmag [3];
    logic signed [TRM_W-1:0]   term_next [3];
    logic [NSQ_W-1:0]          nsq_reg [3];
    logic signed [TRM_W-1:0]   term_reg [3];
    logic                      dg5_reg, v5_reg, en5;

    // stage 6: N and |D|
    logic signed [TRM_W:0]     dsum;
    logic [N_W-1:0]            n6_reg;
    logic [D_W-1:0]            dabs_reg;
    logic                      dg6_reg, v6_reg, en6;

    // stage 7: partials of D^2
    logic [CRD_W-1:0]          dc0, dc1, dc2;
    logic [PRD_W-1:0]          q00_reg, q01_reg, q02_reg, q11_reg, q12_reg, q22_reg;
    logic [N_W-1:0]            n7_reg;
    logic                      dg7_reg, v7_reg, en7;

    // stage 8: half sums of D^2
    logic [D2_W-1:0]           lo8_reg, hi8_reg;
    logic [N_W-1:0]            n8_reg;
    logic                      dg8_reg, v8_reg, en8;

    // stage 9: D^2
    logic [D2_W-1:0]           d2_reg;
    logic [N_W-1:0]            n9_reg;
    logic                      dg9_reg, v9_reg, en9;

    // root search stages
    srch_t                     ent_cur [Q_W];
    logic [D2_W-1:0]           ent_d2 [Q_W];
    logic [N_W-1:0]            ent_n [Q_W];
    logic                      ent_dg [Q_W];
    logic                      ent_v [Q_W];
    srch_t                     sr_next [Q_W];
    srch_t                     sr_reg [Q_W];
    logic [D2_W-1:0]           sd2_reg [Q_W];
    logic [N_W-1:0]            sn_reg [Q_W];
    logic                      sdg_reg [Q_W];
    logic                      sv_reg [Q_W];
    logic                      sen [Q_W];

    // output register
    logic [DIST_W-1:0]         dist_reg;
    logic                      deg_reg, ov_reg, en_out;

    // field unpacking
    for (genvar f = 0; f < 12; f++)
    begin : g_fld
        assign fld[f] = s_tdata[32*f +: 32];
    end

    // stall chain: a stage moves when it is empty or its successor moves
    assign en_out = !ov_reg || m_tready;
    assign sen[Q_W-1] = !sv_reg[Q_W-1] || en_out;
    for (genvar j = 0; j < Q_W-1; j++)
    begin : g_en
        assign sen[j] = !sv_reg[j] || sen[j+1];
    end
    assign en9 = !v9_reg || sen[0];
    assign en8 = !v8_reg || en9;
    assign en7 = !v7_reg || en8;
    assign en6 = !v6_reg || en7;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    // valid bits of the arithmetic stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (en1)    v1_reg <= s_tvalid;
            if (en2)    v2_reg <= v1_reg;
            if (en3)    v3_reg <= v2_reg;
            if (en4)    v4_reg <= v3_reg;
            if (en5)    v5_reg <= v4_reg;
            if (en6)    v6_reg <= v5_reg;
            if (en7)    v7_reg <= v6_reg;
            if (en8)    v8_reg <= v7_reg;
            if (en9)    v9_reg <= v8_reg;
            if (en_out) ov_reg <= sv_reg[Q_W-1];
        end
    end

    // stage 1 logic
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1_next[k]  = CRD_W'(fld[3+k]) - CRD_W'(fld[k]);
            e2_next[k]  = CRD_W'(fld[6+k]) - CRD_W'(fld[k]);
            off_next[k] = CRD_W'(fld[9+k]) - CRD_W'(fld[k]);
        end
    end

    // stage 2 logic: the six cross product terms
    always_comb
    begin
        cp_next[0] = PRD_W'(e1_reg[1]) * PRD_W'(e2_reg[2]);
        cp_next[1] = PRD_W'(e1_reg[2]) * PRD_W'(e2_reg[1]);
        cp_next[2] = PRD_W'(e1_reg[2]) * PRD_W'(e2_reg[0]);
        cp_next[3] = PRD_W'(e1_reg[0]) * PRD_W'(e2_reg[2]);
        cp_next[4] = PRD_W'(e1_reg[0]) * PRD_W'(e2_reg[1]);
        cp_next[5] = PRD_W'(e1_reg[1]) * PRD_W'(e2_reg[0]);
    end

    // stage 3 logic: normal, then sign and magnitude split
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nrm[k] = NRM_W'(cp_reg[2*k]) - NRM_W'(cp_reg[2*k+1]);
            nabs_next[k] = nrm[k][NRM_W-1] ? PRD_W'(-nrm[k]) : nrm[k][PRD_W-1:0];
            oabs_next[k] = off2_reg[k][CRD_W-1] ? CRD_W'(-off2_reg[k]) : off2_reg[k];
        end
    end

    // stage 5 logic: reassemble squares and signed dot terms
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nsq_next[k] = (NSQ_W'(hh_reg[k]) << 66) + (NSQ_W'(lh_reg[k]) << 34)
                        + NSQ_W'(ll_reg[k]);
            tmag[k] = (D_W'(ho_reg[k]) << 33) + D_W'(lo_reg[k]);
            term_next[k] = tneg4_reg[k] ? -TRM_W'(tmag[k]) : TRM_W'(tmag[k]);
        end
    end

    // stage 6 and 7 helpers
    assign dsum = (TRM_W+1)'(term_reg[0]) + (TRM_W+1)'(term_reg[1])
                + (TRM_W+1)'(term_reg[2]);
    assign dc0 = dabs_reg[32:0];
    assign dc1 = dabs_reg[65:33];
    assign dc2 = dabs_reg[98:66];

    // payload of the arithmetic stages
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            e1_reg   <= e1_next;
            e2_reg   <= e2_next;
            off1_reg <= off_next;
        end
        if (en2)
        begin
            cp_reg   <= cp_next;
            off2_reg <= off1_reg;
        end
        if (en3)
        begin
            nabs_reg <= nabs_next;
            oabs_reg <= oabs_next;
            for (int k = 0; k < 3; k++)
                tneg3_reg[k] <= nrm[k][NRM_W-1] ^ off2_reg[k][CRD_W-1];
            dg3_reg <= (nrm[0] == '0) && (nrm[1] == '0) && (nrm[2] == '0);
        end
        if (en4)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ll_reg[k] <= PRD_W'(nabs_reg[k][32:0])  * PRD_W'(nabs_reg[k][32:0]);
                lh_reg[k] <= PRD_W'(nabs_reg[k][32:0])  * PRD_W'(nabs_reg[k][65:33]);
                hh_reg[k] <= PRD_W'(nabs_reg[k][65:33]) * PRD_W'(nabs_reg[k][65:33]);
                lo_reg[k] <= PRD_W'(nabs_reg[k][32:0])  * PRD_W'(oabs_reg[k]);
                ho_reg[k] <= PRD_W'(nabs_reg[k][65:33]) * PRD_W'(oabs_reg[k]);
            end
            tneg4_reg <= tneg3_reg;
            dg4_reg   <= dg3_reg;
        end
        if (en5)
        begin
            nsq_reg  <= nsq_next;
            term_reg <= term_next;
            dg5_reg  <= dg4_reg;
        end
        if (en6)
        begin
            n6_reg   <= N_W'(nsq_reg[0]) + N_W'(nsq_reg[1]) + N_W'(nsq_reg[2]);
            dabs_reg <= dsum[TRM_W] ? D_W'(-dsum) : dsum[D_W-1:0];
            dg6_reg  <= dg5_reg;
        end
        if (en7)
        begin
            q00_reg <= PRD_W'(dc0) * PRD_W'(dc0);
            q01_reg <= PRD_W'(dc0) * PRD_W'(dc1);
            q02_reg <= PRD_W'(dc0) * PRD_W'(dc2);
            q11_reg <= PRD_W'(dc1) * PRD_W'(dc1);
            q12_reg <= PRD_W'(dc1) * PRD_W'(dc2);
            q22_reg <= PRD_W'(dc2) * PRD_W'(dc2);
            n7_reg  <= n6_reg;
            dg7_reg <= dg6_reg;
        end
        if (en8)
        begin
            lo8_reg <= D2_W'(q00_reg) + (D2_W'(q01_reg) << 34) + (D2_W'(q11_reg) << 66);
            hi8_reg <= (D2_W'(q02_reg) << 67) + (D2_W'(q12_reg) << 100)
                     + (D2_W'(q22_reg) << 132);
            n8_reg  <= n7_reg;
            dg8_reg <= dg7_reg;
        end
        if (en9)
        begin
            d2_reg  <= lo8_reg + hi8_reg;
            n9_reg  <= n8_reg;
            dg9_reg <= dg8_reg;
        end
        if (en_out)
        begin
            dist_reg <= sdg_reg[Q_W-1] ? '0 : DIST_W'(sr_reg[Q_W-1].q);
            deg_reg  <= sdg_reg[Q_W-1];
        end
    end

    // root search: one distance bit per stage, most significant first
    for (genvar j = 0; j < Q_W; j++)
    begin : g_root
        localparam int K = Q_W - 1 - j;

        if (j == 0)
        begin : g_first
            assign ent_cur[j] = '0;
            assign ent_d2[j]  = d2_reg;
            assign ent_n[j]   = n9_reg;
            assign ent_dg[j]  = dg9_reg;
            assign ent_v[j]   = v9_reg;
        end
        else
        begin : g_rest
            assign ent_cur[j] = sr_reg[j-1];
            assign ent_d2[j]  = sd2_reg[j-1];
            assign ent_n[j]   = sn_reg[j-1];
            assign ent_dg[j]  = sdg_reg[j-1];
            assign ent_v[j]   = sv_reg[j-1];
        end

        ppd_root_step u_step
        (
            .cur      (ent_cur[j]),
            .p_sh     (SRCH_W'(ent_cur[j].p) << (K + 1)),
            .n_sq_sh  (SRCH_W'(ent_n[j]) << (2 * K)),
            .n_sh     (QN_W'(ent_n[j]) << K),
            .bit_mask (Q_W'(1) << K),
            .d2       (SRCH_W'(ent_d2[j])),
            .nxt      (sr_next[j])
        );

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[j] <= 1'b0;
            else if (sen[j])
                sv_reg[j] <= ent_v[j];
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            if (sen[j])
            begin
                sr_reg[j]  <= sr_next[j];
                sd2_reg[j] <= ent_d2[j];
                sn_reg[j]  <= ent_n[j];
                sdg_reg[j] <= ent_dg[j];
            end
        end
    end

    // result port
    assign m_tvalid = ov_reg;
    assign m_tdata  = {(OUT_W-DIST_W)'(0), dist_reg};
    assign m_tuser  = deg_reg;

endmodule

FILE: rtl/ppd_root_step.sv
`timescale 1ns / 1ps

module ppd_root_step
(
    input  ppd_pkg::srch_t                   cur,
    input  logic [ppd_pkg::SRCH_W-1:0]       p_sh,
    input  logic [ppd_pkg::SRCH_W-1:0]       n_sq_sh,
    input  logic [ppd_pkg::QN_W-1:0]         n_sh,
    input  logic [ppd_pkg::Q_W-1:0]          bit_mask,
    input  logic [ppd_pkg::SRCH_W-1:0]       d2,
    output ppd_pkg::srch_t                   nxt
);
    import ppd_pkg::*;

    logic [SRCH_W-1:0] trial;
    logic              fits;

    // (q + 2^k)^2 * N = q^2 N + q N 2^(k+1) + N 2^(2k)
    assign trial = cur.s + p_sh + n_sq_sh;
    assign fits  = (trial <= d2);

    // keep the bit when the trial square stays within D^2
    always_comb
    begin
        nxt = cur;
        if (fits)
        begin
            nxt.s = trial;
            nxt.p = cur.p + n_sh;
            nxt.q = cur.q | bit_mask;
        end
    end

endmodule

FILE: rtl/ppd_checker.sv
`timescale 1ns / 1ps

module ppd_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tready,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [ppd_pkg::OUT_W-1:0]    m_tdata,
    input  logic                         m_tuser
);
    import ppd_pkg::*;

    // no result shows while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // collinear plane points give distance zero
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[DIST_W-1:0] == '0)
        else $error("degenerate result with nonzero distance");

    // pad bits above the distance stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_W-1:DIST_W] == '0)
        else $error("nonzero pad bits in result");

    // an empty output stage means the whole pipeline can move
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind point_plane_distance_unit ppd_checker u_ppd_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import ppd_pkg::*;

    localparam int N_ITEMS     = 1400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LATENCY     = 43;

    typedef struct {
        logic [IN_W-1:0]   pts;
        bit                known;
        logic [DIST_W-1:0] dist_val;
        logic              degen;
    } row_t;

    typedef struct {
        logic [DIST_W-1:0] dist_val;
        logic              degen;
    } dist_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tuser;

    dist_t dist_queue[$];
    row_t  rows[$];
    int    mismatches;
    int    cycle;

    point_plane_distance_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // exact distance: largest q with q*q*N <= D*D
    function automatic dist_t plane_distance(input logic [IN_W-1:0] pts);
        logic signed [32:0]  e1[3];
        logic signed [32:0]  e2[3];
        logic signed [32:0]  off[3];
        logic signed [66:0]  nrm[3];
        logic signed [135:0] nsq;
        logic signed [101:0] dot;
        logic [255:0]        dmag;
        logic [255:0]        d2;
        logic [255:0]        nlen;
        logic [255:0]        trial;
        logic [50:0]         q;
        logic signed [32:0]  b;
        dist_t               r;
        for (int k = 0; k < 3; k++)
        begin
            b      = {pts[32*k+31], pts[32*k +: 32]};
            e1[k]  = {pts[32*(3+k)+31], pts[32*(3+k) +: 32]} - b;
            e2[k]  = {pts[32*(6+k)+31], pts[32*(6+k) +: 32]} - b;
            off[k] = {pts[32*(9+k)+31], pts[32*(9+k) +: 32]} - b;
        end
        nrm[0] = e1[1] * e2[2] - e1[2] * e2[1];
        nrm[1] = e1[2] * e2[0] - e1[0] * e2[2];
        nrm[2] = e1[0] * e2[1] - e1[1] * e2[0];
        nsq = nrm[0] * nrm[0] + nrm[1] * nrm[1] + nrm[2] * nrm[2];
        if (nsq == 0)
        begin
            r.dist_val = '0;
            r.degen    = 1'b1;
            return r;
        end
        dot  = nrm[0] * off[0] + nrm[1] * off[1] + nrm[2] * off[2];
        dmag = (dot < 0) ? 256'(-dot) : 256'(dot);
        d2   = dmag * dmag;
        nlen = 256'(nsq);
        q    = '0;
        for (int k = DIST_W - 1; k >= 0; k--)
        begin
            trial = 256'(q | (51'd1 << k));
            if (trial * trial * nlen <= d2)
                q = q | (51'd1 << k);
        end
        r.dist_val = q;
        r.degen    = 1'b0;
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_points(input int c[12]);
        logic [IN_W-1:0] v;
        for (int k = 0; k < 12; k++)
            v[32*k +: 32] = c[k];
        return v;
    endfunction

    task automatic add_row(input int c[12], input bit known, input longint exp_dist,
                           input bit degen);
        row_t r;
        r.pts      = pack_points(c);
        r.known    = known;
        r.dist_val = exp_dist[DIST_W-1:0];
        r.degen    = degen;
        rows.push_back(r);
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    // random geometry, mostly well formed, some collinear and extreme
    function automatic logic [IN_W-1:0] random_points();
        int c[12];
        int dir[3];
        int m;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                for (int k = 0; k < 12; k++) c[k] = $urandom;
            4, 5:
                for (int k = 0; k < 12; k++) c[k] = $signed($urandom_range(0, 2097151)) - 1048576;
            6:
            begin
                m = $signed($urandom_range(0, 14)) - 7;
                for (int k = 0; k < 3; k++)
                begin
                    c[k]     = $signed($urandom_range(0, 2097151)) - 1048576;
                    dir[k]   = $signed($urandom_range(0, 131071)) - 65536;
                    c[3+k]   = c[k] + dir[k];
                    c[6+k]   = c[k] + m * dir[k];
                    c[9+k]   = $urandom;
                end
            end
            7:
            begin
                for (int k = 0; k < 12; k++) c[k] = $urandom;
                for (int k = 0; k < 3; k++) c[3+k] = c[k];
            end
            default:
                for (int k = 0; k < 12; k++) c[k] = pick_extreme();
        endcase
        return pack_points(c);
    endfunction

    // directed rows
    initial
    begin
        int one;
        one = 65536;
        add_row('{default: 0}, 1'b1, 0, 1'b1);
        add_row('{0,0,0, one,0,0, 0,one,0, 0,0,5*one}, 1'b1, 5*65536, 1'b0);
        add_row('{0,0,0, one,0,0, 0,one,0, 7,9,-3*one}, 1'b1, 3*65536, 1'b0);
        add_row('{0,0,0, one,0,0, 0,one,0, 123,-456,0}, 1'b1, 0, 1'b0);
        add_row('{one,one,one, 2*one,2*one,2*one, 3*one,3*one,3*one, 0,0,0},
                1'b1, 0, 1'b1);
        add_row('{default: 32'h7fff_ffff}, 1'b1, 0, 1'b1);
        add_row('{default: 32'h8000_0000}, 1'b1, 0, 1'b1);
        add_row('{32'h8000_0000,32'h8000_0000,32'h8000_0000,
                  32'h7fff_ffff,32'h8000_0000,32'h8000_0000,
                  32'h8000_0000,32'h7fff_ffff,32'h8000_0000,
                  32'h8000_0000,32'h8000_0000,32'h7fff_ffff}, 1'b0, 0, 1'b0);
        add_row('{32'h7fff_ffff,32'h7fff_ffff,32'h7fff_ffff,
                  32'h8000_0000,32'h7fff_ffff,32'h7fff_ffff,
                  32'h7fff_ffff,32'h8000_0000,32'h7fff_ffff,
                  32'h8000_0000,32'h8000_0000,32'h8000_0000}, 1'b0, 0, 1'b0);
        add_row('{32'h8000_0000,0,32'h7fff_ffff, 32'h7fff_ffff,32'h8000_0000,0,
                  0,32'h7fff_ffff,32'h8000_0000, -1,-1,-1}, 1'b0, 0, 1'b0);
        add_row('{0,0,0, 1,0,0, 0,1,0, 0,0,1}, 1'b1, 1, 1'b0);
        add_row('{0,0,0, 0,0,0, one,2*one,3*one, 4*one,5*one,6*one}, 1'b1, 0, 1'b1);
    end

    // request driver
    initial
    begin
        int    total;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #0;
        total = rows.size() + N_ITEMS;
        for (int i = 0; i < total; i++)
        begin
            // one pause until the pipeline drains
            if (i == 1000)
            begin
                s_tvalid <= 1'b0;
                while (dist_queue.size() != 0) @(posedge clk);
            end
            // random gaps, none during the steady stretch
            if (!(i >= 500 && i < 700))
            begin
                while ($urandom_range(0, 99) < 11)
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                end
            end
            if (i < rows.size())
                s_tdata <= rows[i].pts;
            else
                s_tdata <= random_points();
            s_tvalid <= 1'b1;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
        end
        s_tvalid <= 1'b0;
        while (dist_queue.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && dist_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // result receiver, with one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cycle >= 400 && cycle < 650)
                m_tready <= 1'b0;
            else if (cycle >= 1200 && cycle < 1800)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 11);
        end
    end

    // prediction on accepted requests, checking on accepted results
    always @(posedge clk)
    begin
        dist_t exp_r;
        if (rst_n && s_tvalid && s_tready)
        begin
            exp_r = plane_distance(s_tdata);
            foreach (rows[j])
            begin
                if (rows[j].known && rows[j].pts === s_tdata)
                begin
                    exp_r.dist_val = rows[j].dist_val;
                    exp_r.degen    = rows[j].degen;
                end
            end
            dist_queue.push_back(exp_r);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (dist_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result dist=%0d degen=%0b",
                             m_tdata[DIST_W-1:0], m_tuser);
            end
            else
            begin
                exp_r = dist_queue.pop_front();
                if (m_tdata[DIST_W-1:0] !== exp_r.dist_val || m_tuser !== exp_r.degen)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: dist exp %0d got %0d, degen exp %0b got %0b",
                                 exp_r.dist_val, m_tdata[DIST_W-1:0], exp_r.degen, m_tuser);
                end
            end
        end
    end

    // cycle count and timeout
    initial cycle = 0;
    initial mismatches = 0;
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
